// ----- hdl/gcmd_pkg.sv -----
`default_nettype none
package gcmd_pkg;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int SUM_W          = 48;

    localparam logic [2:0] REG_X_ORIGIN  = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN  = 3'd1;
    localparam logic [2:0] REG_X_CELL    = 3'd2;
    localparam logic [2:0] REG_Y_CELL    = 3'd3;
    localparam logic [2:0] REG_ROWS_USED = 3'd4;
    localparam logic [2:0] REG_COLS_USED = 3'd5;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [5:0]         read_row;
        logic [5:0]         read_col;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mean_x;
        logic signed [31:0] mean_y;
        logic signed [31:0] mean_z;
        logic [15:0]        point_count;
        logic               occupied;
    } out_item_t;

    // Divider request and response.
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [47:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- hdl/grid_cell_mean_downsampler_core.sv -----
`default_nettype none
// Accumulate: two divider passes for the row and column index, then a read and a
// write-back of the cell; no new item is taken until the write-back is done.
// Read: three passes of the shared divider divide the sums by the count, skipped for an
// empty cell or a read outside the store; the next item can be taken in the cycle
// after the result transfer. After reset a clearing pass writes zeros to all
// MAX_ROWS*MAX_COLS cells, one a cycle, while in_stall stays high; configuration is taken.
module grid_cell_mean_downsampler_core #(
    parameter int MAX_ROWS   = gcmd_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = gcmd_pkg::MAX_COLS_DEF,
    parameter int COUNT_BITS = gcmd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire gcmd_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output gcmd_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DROW  = 4'd2;
    localparam logic [3:0] S_DCOL  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WB    = 4'd5;
    localparam logic [3:0] S_DX    = 4'd6;
    localparam logic [3:0] S_DY    = 4'd7;
    localparam logic [3:0] S_DZ    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Configuration registers; they are always writable.
    logic signed [31:0] x_origin_reg, y_origin_reg;
    logic [30:0]        x_cell_reg, y_cell_reg;
    logic [6:0]         rows_used_reg, cols_used_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg  <= '0;
            y_origin_reg  <= '0;
            x_cell_reg    <= 31'd65536;
            y_cell_reg    <= 31'd65536;
            rows_used_reg <= 7'd64;
            cols_used_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gcmd_pkg::REG_X_ORIGIN:  x_origin_reg  <= cfg_data;
                gcmd_pkg::REG_Y_ORIGIN:  y_origin_reg  <= cfg_data;
                gcmd_pkg::REG_X_CELL:    x_cell_reg    <= cfg_data[30:0];
                gcmd_pkg::REG_Y_CELL:    y_cell_reg    <= cfg_data[30:0];
                gcmd_pkg::REG_ROWS_USED: rows_used_reg <= cfg_data[6:0];
                gcmd_pkg::REG_COLS_USED: cols_used_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective limits minus one: zero acts as one, and the top is capped at the maximum.
    logic [10:0] row_lim_m1, col_lim_m1;
    always_comb
    begin
        if (rows_used_reg == 7'd0)
            row_lim_m1 = '0;
        else if (32'(rows_used_reg) > 32'(MAX_ROWS))
            row_lim_m1 = 11'(MAX_ROWS - 1);
        else
            row_lim_m1 = 11'(rows_used_reg) - 11'd1;
        if (cols_used_reg == 7'd0)
            col_lim_m1 = '0;
        else if (32'(cols_used_reg) > 32'(MAX_COLS))
            col_lim_m1 = 11'(MAX_COLS - 1);
        else
            col_lim_m1 = 11'(cols_used_reg) - 11'd1;
    end

    logic [3:0]           state_reg, state_next;
    gcmd_pkg::in_item_t   item_reg;
    logic [ADDR_W-1:0]    clr_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 skip_reg;
    logic [47:0]          sx_reg, sy_reg, sz_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    gcmd_pkg::out_item_t  res_reg;
    logic                 out_valid_reg;
    logic                 sign_reg;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // Shared divider.
    gcmd_pkg::div_req_t dreq;
    gcmd_pkg::div_rsp_t drsp;
    gcmd_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Index operands: d = coord - origin, exact in 33 bits.
    logic signed [32:0] dx, dy;
    assign dx = 33'(item_reg.px) - 33'(x_origin_reg);
    assign dy = 33'(item_reg.py) - 33'(y_origin_reg);

    logic [47:0] mag_x, mag_y, mag_z;
    assign mag_x = sx_reg[47] ? (48'd0 - sx_reg) : sx_reg;
    assign mag_y = sy_reg[47] ? (48'd0 - sy_reg) : sy_reg;
    assign mag_z = sz_reg[47] ? (48'd0 - sz_reg) : sz_reg;

    // Division start pulses, one per step.
    logic start_reg;
    always_comb
    begin
        dreq.start    = start_reg;
        dreq.dividend = '0;
        dreq.divisor  = 48'd1;
        unique case (state_reg)
            S_DROW:
            begin
                dreq.dividend = 48'(dx - 33'sd1);
                dreq.divisor  = 48'(x_cell_reg);
            end
            S_DCOL:
            begin
                dreq.dividend = 48'(dy - 33'sd1);
                dreq.divisor  = 48'(y_cell_reg);
            end
            S_DX:
            begin
                dreq.dividend = mag_x;
                dreq.divisor  = 48'(cnt_reg);
            end
            S_DY:
            begin
                dreq.dividend = mag_y;
                dreq.divisor  = 48'(cnt_reg);
            end
            S_DZ:
            begin
                dreq.dividend = mag_z;
                dreq.divisor  = 48'(cnt_reg);
            end
            default: ;
        endcase
    end

    // Clamp a quotient against a limit.
    logic [10:0] q_row, q_col;
    always_comb
    begin
        if (dx <= 33'sd0 || x_cell_reg == '0)
            q_row = '0;
        else if (drsp.quotient > 48'(row_lim_m1))
            q_row = row_lim_m1;
        else
            q_row = drsp.quotient[10:0];
        if (dy <= 33'sd0 || y_cell_reg == '0)
            q_col = '0;
        else if (drsp.quotient > 48'(col_lim_m1))
            q_col = col_lim_m1;
        else
            q_col = drsp.quotient[10:0];
    end

    logic [31:0] q_signed;
    logic [47:0] q_neg;
    assign q_neg    = 48'd0 - drsp.quotient;
    assign q_signed = sign_reg ? q_neg[31:0] : drsp.quotient[31:0];

    // Store ports.
    logic               st_rd_en, st_wr_en;
    logic [ADDR_W-1:0]  st_rd_addr, st_wr_addr;
    logic [47:0]        rd_sx, rd_sy, rd_sz, wr_sx, wr_sy, wr_sz;
    logic [COUNT_BITS-1:0] rd_cnt, wr_cnt;
    logic [ADDR_W-1:0]  item_addr;

    always_comb
    begin
        if (item_reg.opcode == gcmd_pkg::OP_READ)
            item_addr = ADDR_W'(32'(item_reg.read_row) * MAX_COLS + 32'(item_reg.read_col));
        else
            item_addr = ADDR_W'(32'(row_reg) * MAX_COLS + 32'(col_reg));
    end

    assign st_rd_en   = (state_reg == S_RD);
    assign st_rd_addr = item_addr;

    always_comb
    begin
        st_wr_en   = 1'b0;
        st_wr_addr = item_addr;
        wr_sx      = '0;
        wr_sy      = '0;
        wr_sz      = '0;
        wr_cnt     = '0;
        if (state_reg == S_CLEAR)
        begin
            st_wr_en   = 1'b1;
            st_wr_addr = clr_reg;
        end
        else if (state_reg == S_WB && !skip_reg)
        begin
            if (item_reg.opcode == gcmd_pkg::OP_READ)
                st_wr_en = 1'b1;
            else if (rd_cnt != COUNT_MAX)
            begin
                st_wr_en = 1'b1;
                wr_sx    = rd_sx + 48'(item_reg.px);
                wr_sy    = rd_sy + 48'(item_reg.py);
                wr_sz    = rd_sz + 48'(item_reg.pz);
                wr_cnt   = rd_cnt + 1'b1;
            end
        end
    end

    gcmd_store #(.DEPTH(CELLS), .ADDR_W(ADDR_W), .COUNT_W(COUNT_BITS)) u_store (
        .clk(clk), .rd_en(st_rd_en), .rd_addr(st_rd_addr),
        .rd_sx(rd_sx), .rd_sy(rd_sy), .rd_sz(rd_sz), .rd_cnt(rd_cnt),
        .wr_en(st_wr_en), .wr_addr(st_wr_addr),
        .wr_sx(wr_sx), .wr_sy(wr_sy), .wr_sz(wr_sz), .wr_cnt(wr_cnt)
    );

    // Reads outside the store leave it untouched and return the empty answer.
    logic read_outside;
    assign read_outside = (32'(in_data.read_row) >= MAX_ROWS)
                       || (32'(in_data.read_col) >= MAX_COLS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_fire)
                    state_next = (in_data.opcode == gcmd_pkg::OP_READ) ? S_RD : S_DROW;
            S_DROW:  if (drsp.done) state_next = S_DCOL;
            S_DCOL:  if (drsp.done) state_next = S_RD;
            S_RD:    state_next = S_WB;
            S_WB:
                if (item_reg.opcode == gcmd_pkg::OP_READ)
                    state_next = (skip_reg || rd_cnt == '0) ? S_OUT : S_DX;
                else
                    state_next = S_IDLE;
            S_DX:    if (drsp.done) state_next = S_DY;
            S_DY:    if (drsp.done) state_next = S_DZ;
            S_DZ:    if (drsp.done) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            start_reg <= (state_next != state_reg)
                      && (state_next == S_DROW || state_next == S_DCOL
                          || state_next == S_DX || state_next == S_DY
                          || state_next == S_DZ);
            if (out_fire)
                out_valid_reg <= 1'b0;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
            skip_reg <= (in_data.opcode == gcmd_pkg::OP_READ) && read_outside;
            res_reg  <= '0;
        end
        if (state_reg == S_DROW && drsp.done)
            row_reg <= ROW_W'(q_row);
        if (state_reg == S_DCOL && drsp.done)
            col_reg <= COL_W'(q_col);
        if (state_reg == S_WB)
        begin
            sx_reg  <= rd_sx;
            sy_reg  <= rd_sy;
            sz_reg  <= rd_sz;
            cnt_reg <= rd_cnt;
            if (item_reg.opcode == gcmd_pkg::OP_READ && !skip_reg && rd_cnt != '0)
            begin
                res_reg.point_count <= 16'(rd_cnt);
                res_reg.occupied    <= 1'b1;
            end
        end
        if (state_next == S_DX && state_reg != S_DX)
            sign_reg <= rd_sx[47];
        if (state_next == S_DY && state_reg != S_DY)
            sign_reg <= sx_reg[47] ^ sx_reg[47] ^ sy_reg[47];
        if (state_next == S_DZ && state_reg != S_DZ)
            sign_reg <= sz_reg[47];
        if (drsp.done && state_reg == S_DX) res_reg.mean_x <= q_signed;
        if (drsp.done && state_reg == S_DY) res_reg.mean_y <= q_signed;
        if (drsp.done && state_reg == S_DZ) res_reg.mean_z <= q_signed;
    end

    // No new item is taken while a result waits or the sequencer is busy.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> (state_reg == S_IDLE))
        else $error("item accepted while busy");
    // A result appears only after the output step of a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output step");
    // A waiting result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(res_reg))
        else $error("stalled result changed");
endmodule
`default_nettype wire

// ----- hdl/gcmd_divider.sv -----
`default_nettype none
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
module gcmd_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gcmd_pkg::div_req_t req,
    output gcmd_pkg::div_rsp_t     rsp
);
    logic [47:0] quo_reg;
    logic [47:0] rem_reg;
    logic [47:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] trial;

    assign trial = {rem_reg, quo_reg[47]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd48;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[48])
            begin
                rem_reg <= trial[47:0];
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[46:0], quo_reg[47]};
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign rsp = {done_reg, quo_reg};
endmodule
`default_nettype wire

// ----- hdl/gcmd_store.sv -----
`default_nettype none
// Cell store: three sum memories and a count memory, with a registered read.
module gcmd_store #(
    parameter int DEPTH   = 4096,
    parameter int ADDR_W  = 12,
    parameter int COUNT_W = 16
) (
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output logic [47:0]              rd_sx,
    output logic [47:0]              rd_sy,
    output logic [47:0]              rd_sz,
    output logic [COUNT_W-1:0]       rd_cnt,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire logic [47:0]         wr_sx,
    input  wire logic [47:0]         wr_sy,
    input  wire logic [47:0]         wr_sz,
    input  wire logic [COUNT_W-1:0]  wr_cnt
);
    logic [47:0]        mem_sx [DEPTH];
    logic [47:0]        mem_sy [DEPTH];
    logic [47:0]        mem_sz [DEPTH];
    logic [COUNT_W-1:0] mem_cnt [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_sx[wr_addr]  <= wr_sx;
            mem_sy[wr_addr]  <= wr_sy;
            mem_sz[wr_addr]  <= wr_sz;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_sx  <= mem_sx[rd_addr];
            rd_sy  <= mem_sy[rd_addr];
            rd_sz  <= mem_sz[rd_addr];
            rd_cnt <= mem_cnt[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/grid_cell_mean_downsampler_core_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the grid mean downsampler. Points are binned into a
// row and column from their x and y coordinates, and reads return the mean
// of one cell before clearing it. A behavioural copy of the grid runs
// alongside the block. Every read transfer that the block accepts queues one
// expected mean, and each result transfer is checked against the oldest
// entry in that queue.
module grid_cell_mean_downsampler_core_tb;

    localparam int GRID_COLS = 64;
    localparam int GRID_CELLS = 64 * 64;
    localparam int SETTLE_CYCLES = 250;  // longer than a read

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    gcmd_pkg::in_item_t   in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    gcmd_pkg::out_item_t  out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    grid_cell_mean_downsampler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the configuration registers, as the block should hold them.
    logic signed [31:0] grid_x_org = 0;
    logic signed [31:0] grid_y_org = 0;
    logic [30:0]        grid_x_size = 31'd65536;
    logic [30:0]        grid_y_size = 31'd65536;
    logic [6:0]         grid_rows = 7'd64;
    logic [6:0]         grid_cols = 7'd64;

    // Shadow copy of the cell store. It is all zero after reset.
    logic signed [47:0] cell_sum_x [GRID_CELLS];
    logic signed [47:0] cell_sum_y [GRID_CELLS];
    logic signed [47:0] cell_sum_z [GRID_CELLS];
    logic [15:0]        cell_count [GRID_CELLS];

    gcmd_pkg::out_item_t pending_means[$];  // expected read results, oldest first
    int        filled_cells[$];   // cells that points were added to, used to aim reads
    int        fail_count = 0;
    bit        no_idle = 1'b0;    // when set, neither side inserts gaps or stalls
    int        stall_left = 0;

    typedef struct {
        gcmd_pkg::in_item_t  item;
        bit                  fixed;
        gcmd_pkg::out_item_t mean;
    } dir_row_t;

    // Maps one coordinate to a grid index along one axis. A zero cell size
    // sends every point to index 0. A limit of 0 counts as 1, and a limit
    // above 64 counts as 64.
    function automatic int axis_index(logic signed [31:0] coord, logic signed [31:0] org,
                                      logic [30:0] csize, logic [6:0] used);
        longint offs;
        longint idx;
        longint lim;
        offs = longint'(coord) - longint'(org);
        lim  = (used == 0) ? 1 : ((used > 64) ? 64 : longint'(used));
        idx  = 0;
        if (csize != 0 && offs > 0)
            idx = (offs - 1) / longint'({33'd0, csize});
        if (idx > lim - 1)
            idx = lim - 1;
        return int'(idx);
    endfunction

    // Applies one item to the shadow grid. It returns 1 when the item yields a result.
    function automatic bit grid_step(gcmd_pkg::in_item_t it, output gcmd_pkg::out_item_t mean);
        int     addr;
        longint n;
        mean = '0;
        if (it.opcode == gcmd_pkg::OP_ACCUM) begin
            addr = axis_index(it.px, grid_x_org, grid_x_size, grid_rows) * GRID_COLS
                   + axis_index(it.py, grid_y_org, grid_y_size, grid_cols);
            // A cell whose count is already full ignores further points.
            if (cell_count[addr] != 16'hFFFF) begin
                cell_sum_x[addr] += {{16{it.px[31]}}, it.px};
                cell_sum_y[addr] += {{16{it.py[31]}}, it.py};
                cell_sum_z[addr] += {{16{it.pz[31]}}, it.pz};
                cell_count[addr] += 16'd1;
                filled_cells.insert(filled_cells.size(), addr);
                if (filled_cells.size() > 32)
                    void'(filled_cells.pop_front());
            end
            return 1'b0;
        end
        addr = int'(it.read_row) * GRID_COLS + int'(it.read_col);
        n = longint'(cell_count[addr]);
        // An empty cell reads back as all zero. Division truncates toward zero.
        if (n != 0) begin
            mean.mean_x      = 32'(longint'(cell_sum_x[addr]) / n);
            mean.mean_y      = 32'(longint'(cell_sum_y[addr]) / n);
            mean.mean_z      = 32'(longint'(cell_sum_z[addr]) / n);
            mean.point_count = cell_count[addr];
            mean.occupied    = 1'b1;
        end
        cell_sum_x[addr] = '0;
        cell_sum_y[addr] = '0;
        cell_sum_z[addr] = '0;
        cell_count[addr] = '0;
        return 1'b1;
    endfunction

    // Result side: unless no_idle is set, stalls for a random number of cycles after each
    // transfer, and checks each transfer against the oldest expected mean.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_means.size() == 0) begin
                $error("unexpected result transfer: %p", out_data);
                fail_count++;
            end else begin
                automatic gcmd_pkg::out_item_t want = pending_means.pop_front();
                if (out_data.mean_x !== want.mean_x) begin
                    $error("mean_x expected %0d actual %0d", want.mean_x, out_data.mean_x);
                    fail_count++;
                end
                if (out_data.mean_y !== want.mean_y) begin
                    $error("mean_y expected %0d actual %0d", want.mean_y, out_data.mean_y);
                    fail_count++;
                end
                if (out_data.mean_z !== want.mean_z) begin
                    $error("mean_z expected %0d actual %0d", want.mean_z, out_data.mean_z);
                    fail_count++;
                end
                if (out_data.point_count !== want.point_count) begin
                    $error("point_count expected %0d actual %0d",
                           want.point_count, out_data.point_count);
                    fail_count++;
                end
                if (out_data.occupied !== want.occupied) begin
                    $error("occupied expected %0d actual %0d",
                           want.occupied, out_data.occupied);
                    fail_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 19);
        end
        out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    // Presents one item, after a random gap unless no_idle is set, and holds it until the block
    // takes it. The item is applied to the shadow grid at the edge of the transfer.
    task automatic send_item(gcmd_pkg::in_item_t it, bit fixed,
                             gcmd_pkg::out_item_t fixed_mean);
        int                  gap;
        gcmd_pkg::out_item_t mean;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (grid_step(it, mean))
            pending_means.insert(pending_means.size(), fixed ? fixed_mean : mean);
    endtask

    // Waits until every expected mean has arrived. It then allows for an
    // accumulate that may still be in progress, since that yields no result.
    task automatic drain_grid();
        in_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all six registers while the block is idle.
    task automatic set_grid(logic [31:0] xo, logic [31:0] yo, logic [31:0] xs,
                            logic [31:0] ys, logic [31:0] nr, logic [31:0] nc);
        logic [31:0] vals [6];
        logic [2:0]  idx [6];
        vals = '{xo, yo, xs, ys, nr, nc};
        idx  = '{gcmd_pkg::REG_X_ORIGIN, gcmd_pkg::REG_Y_ORIGIN, gcmd_pkg::REG_X_CELL,
                 gcmd_pkg::REG_Y_CELL, gcmd_pkg::REG_ROWS_USED, gcmd_pkg::REG_COLS_USED};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                gcmd_pkg::REG_X_ORIGIN:  grid_x_org  = vals[i];
                gcmd_pkg::REG_Y_ORIGIN:  grid_y_org  = vals[i];
                gcmd_pkg::REG_X_CELL:    grid_x_size = vals[i][30:0];
                gcmd_pkg::REG_Y_CELL:    grid_y_size = vals[i][30:0];
                gcmd_pkg::REG_ROWS_USED: grid_rows   = vals[i][6:0];
                gcmd_pkg::REG_COLS_USED: grid_cols   = vals[i][6:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Draws a point that usually lands near the origin, within a few cells,
    // and sometimes anywhere in the full range.
    function automatic logic [31:0] near_point(logic [31:0] org, logic [30:0] csize);
        logic [31:0] span;
        span = (csize == 0 || csize > 31'h0010_0000) ? 32'h0004_0000 : {1'b0, csize} * 5;
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        return org + $urandom_range(0, span) - {1'b0, csize};
    endfunction

    initial begin
        dir_row_t            dir_tab[$];
        gcmd_pkg::in_item_t  it;
        int                  pick;
        gcmd_pkg::out_item_t none;
        none = '0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            cell_sum_x[i] = '0;
            cell_sum_y[i] = '0;
            cell_sum_z[i] = '0;
            cell_count[i] = '0;
        end

        // Directed rows, at the reset configuration. The expected mean is
        // typed in only where it is obvious, such as an empty cell or a cell
        // that holds a single point.
        dir_tab = '{
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd3, 6'd5}, 1'b1, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd63, 6'd63}, 1'b1, '0},
            // The largest x saturates to the last row. A negative y goes to column 0.
            '{'{gcmd_pkg::OP_ACCUM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd63, 6'd0}, 1'b1,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 16'd1, 1'b1}},
            '{'{gcmd_pkg::OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                6'd63, 6'd63}, 1'b0, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd0, 6'd63}, 1'b1,
              '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1, 1'b1}},
            // A second read of a cell finds it cleared.
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd0, 6'd63}, 1'b1, '0},
            // A point exactly on a cell edge belongs to the lower cell.
            '{'{gcmd_pkg::OP_ACCUM, 32'sd65536, 32'sd131072, 32'sd9, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_ACCUM, 32'sd65537, 32'sd131073, -32'sd9, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd0, 6'd1}, 1'b1,
              '{32'sd65536, 32'sd131072, 32'sd9, 16'd1, 1'b1}},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd1, 6'd2}, 1'b1,
              '{32'sd65537, 32'sd131073, -32'sd9, 16'd1, 1'b1}},
            // Negative means are truncated toward zero.
            '{'{gcmd_pkg::OP_ACCUM, -32'sd3, 32'sd5, -32'sd1, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_ACCUM, -32'sd4, 32'sd6, -32'sd2, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_ACCUM, -32'sd4, 32'sd6, 32'sd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_ACCUM, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF,
                6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_ACCUM, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF,
                6'd0, 6'd0}, 1'b0, '0},
            '{'{gcmd_pkg::OP_READ, 32'sd0, 32'sd0, 32'sd0, 6'd63, 6'd0}, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The block stalls its input until its clearing pass is over.
        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].mean);
        drain_grid();

        // Random phases, each with its own grid setting. The first setting is
        // a small grid. The second has zero and maximal cell sizes with the
        // limits out of range. The third uses extreme origins and runs with
        // no gaps or stalls. The fourth is drawn at random, the fifth has
        // smaller cells, and the last restores the reset values.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_grid(32'd0, 32'd0, 32'd65536, 32'd65536, 32'd4, 32'd4);
                1: set_grid(32'hFFFB_0000, 32'h0003_0000, 32'h7FFF_FFFF, 32'd0,
                            32'd0, 32'hFFFF_FFFF);
                2: set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h0001_8000,
                            32'd64, 32'd1);
                3: set_grid($urandom, $urandom, $urandom_range(1, 32'h0010_0000),
                            $urandom_range(1, 32'h0010_0000), $urandom_range(1, 64),
                            $urandom_range(1, 64));
                4: set_grid(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0000_4000,
                            32'd64, 32'd64);
                default: set_grid(32'd0, 32'd0, 32'd65536, 32'd65536, 32'd64, 32'd64);
            endcase
            no_idle = (ph == 2);
            for (int n = 0; n < 100; n++) begin
                it = '0;
                it.opcode = ($urandom_range(0, 99) < 30) ? gcmd_pkg::OP_READ
                                                         : gcmd_pkg::OP_ACCUM;
                it.px = near_point(grid_x_org, grid_x_size);
                it.py = near_point(grid_y_org, grid_y_size);
                it.pz = ($urandom_range(0, 1) == 1) ? $urandom
                                                    : $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
                if (filled_cells.size() > 0 && $urandom_range(0, 9) < 7) begin
                    pick = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
                    it.read_row = 6'(pick / GRID_COLS);
                    it.read_col = 6'(pick % GRID_COLS);
                end else begin
                    it.read_row = $urandom_range(0, 63);
                    it.read_col = $urandom_range(0, 63);
                end
                send_item(it, 1'b0, none);
                // Partway through one phase the sender holds back until every
                // expected mean has arrived.
                if (ph == 1 && n == 50)
                    drain_grid();
            end
            drain_grid();
        end
        no_idle = 1'b0;

        if (fail_count == 0)
            $display("PASS grid_cell_mean_downsampler_core");
        else
            $display("FAIL grid_cell_mean_downsampler_core");
        $finish;
    end

    // Overall limit for the run, set well above the time a correct run needs.
    initial begin
        #20ms;
        $display("FAIL grid_cell_mean_downsampler_core");
        $finish;
    end
endmodule
